[rtl/ntc_pkg.sv]
// Shared types and constants of the NTC thermometer with moving average.
// No dependencies; ntc_div, ntc_front, ntc_back and the top level use this package.
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int AVERAGE_DEPTH = 20;
  localparam int SAMPLE_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int LOG_FRAC = 24;
  localparam int LOG_W = 5 + LOG_FRAC;
  localparam int DIV_W = 64;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
  localparam logic signed [32:0] LN2_Q32 = 33'sh0B17217F8;
  localparam logic [DIV_W-1:0] CENTI_Q56 = 64'd100 << 56;
  localparam logic signed [DIV_W-1:0] KELVIN_CENTI = 64'sd27315;
  localparam logic signed [DIV_W-1:0] LOW_LIMIT = -64'sd10000;
  localparam logic signed [DIV_W-1:0] SAT_HIGH = 64'sd32767;
  localparam logic signed [15:0] FAULT_TEMP = 16'sd20000;
  localparam logic signed [15:0] SAT_TEMP = 16'sd32767;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_TEMP = 3'd3;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic               fault;
  } out_item_t;

  typedef struct packed {
    logic [19:0]        nominal_resistance;
    logic [19:0]        series_resistance;
    logic [15:0]        beta_factor;
    logic signed [14:0] nominal_temp_centi;
  } cfg_t;

endpackage

[rtl/ntc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ntc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 20,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ntc_queue.sv]
// Short register queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

module ntc_queue #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full = (count_r == (PW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/ntc_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on ntc_pkg.
`timescale 1ns / 1ps

module ntc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ntc_pkg::DIV_W-1:0] dividend,
  input  logic [ntc_pkg::DIV_W-1:0] divisor,
  output logic                    done,
  output logic [ntc_pkg::DIV_W-1:0] quotient
);

  localparam int W = ntc_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;
  logic          take;

  assign trial = {rem_r, quo_r[W-1]};
  assign take = (trial >= {1'b0, dvs_r});
  assign done = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], take};
      rem_r <= take ? W'(trial - {1'b0, dvs_r}) : W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/ntc_front.sv]
// Front part: accepts items, keeps the sample ring and running sum, forms the mean.
// Depends on ntc_pkg and ntc_ram.
`timescale 1ns / 1ps

module ntc_front #(
  parameter int AVERAGE_DEPTH = ntc_pkg::AVERAGE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  ntc_pkg::in_item_t             in_data,
  output logic                          in_full,
  output logic                          mean_push,
  output logic [ntc_pkg::SAMPLE_W-1:0]  mean,
  input  logic                          mean_full
);

  localparam int SW = ntc_pkg::SAMPLE_W;
  localparam int AW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int SUM_W = SW + ((AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 0);
  localparam int RECIP_SH = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  // ceil(2^RECIP_SH / depth): exact floor division for every sum below 2^SUM_W.
  localparam longint RECIP_VAL =
    ((longint'(1) << RECIP_SH) + longint'(AVERAGE_DEPTH) - 1) / longint'(AVERAGE_DEPTH);

  typedef enum logic [1:0] {F_IDLE, F_UPD, F_DIV, F_PUSH} fstate_t;

  fstate_t                  state_r;
  logic [AW-1:0]            ptr_r;
  logic [AVERAGE_DEPTH-1:0] valid_r;
  logic [SW-1:0]            prime_val_r;
  logic [SW-1:0]            sample_r;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         dq_r;
  logic [SW-1:0]            ram_rdata;
  logic [SW-1:0]            old_val;
  logic [SUM_W-1:0]         sum_nxt;
  logic [PROD_W-1:0]        prod;
  logic                     accept;

  ntc_ram #(.WIDTH(SW), .DEPTH(AVERAGE_DEPTH), .AW(AW)) u_ring (
    .clk   (clk),
    .we    (state_r == F_UPD),
    .waddr (ptr_r),
    .wdata (sample_r),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign in_full = (state_r != F_IDLE);
  assign accept = in_push && (state_r == F_IDLE);
  // Entries untouched since the last prime (or reset) read as the prime value.
  assign old_val = valid_r[ptr_r] ? ram_rdata : prime_val_r;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
  assign prod = PROD_W'(dq_r) * PROD_W'(RECIP_VAL);
  assign mean_push = (state_r == F_PUSH);
  assign mean = dq_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ptr_r <= '0;
      valid_r <= '0;
      prime_val_r <= '0;
      sum_r <= '0;
      sample_r <= '0;
      dq_r <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            sample_r <= in_data.sample;
            if (in_data.op) begin
              state_r <= F_UPD;
            end else begin
              prime_val_r <= in_data.sample;
              valid_r <= '0;
              sum_r <= SUM_W'(in_data.sample) * SUM_W'(AVERAGE_DEPTH);
            end
          end
        end
        F_UPD: begin
          sum_r <= sum_nxt;
          dq_r <= sum_nxt;
          valid_r[ptr_r] <= 1'b1;
          ptr_r <= (ptr_r == AW'(AVERAGE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
          state_r <= F_DIV;
        end
        F_DIV: begin
          // Mean by reciprocal multiply and shift.
          dq_r <= SUM_W'(prod >> RECIP_SH);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!mean_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/ntc_back.sv]
// Back part: converts a mean to a temperature with the beta equation.
// Depends on ntc_pkg and ntc_div.
`timescale 1ns / 1ps

module ntc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ntc_pkg::cfg_t                cfg,
  input  logic                         mean_empty,
  input  logic [ntc_pkg::SAMPLE_W-1:0] mean,
  output logic                         mean_pop,
  output logic                         out_empty,
  output ntc_pkg::out_item_t           out_data,
  input  logic                         out_pop
);

  localparam int W = ntc_pkg::DIV_W;
  localparam int LW = ntc_pkg::LOG_W;
  localparam int FW = ntc_pkg::LOG_FRAC;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_NORM, B_SQR, B_LN, B_DIVB, B_DIVT, B_CHECK, B_DIVQ, B_DONE
  } bstate_t;

  bstate_t              state_r;
  logic [11:0]          m_r;
  logic                 den_phase_r;
  logic [31:0]          x_r;
  logic [4:0]           top_r;
  logic [FW-1:0]        frac_r;
  logic [4:0]           cnt_r;
  logic [LW-1:0]        lognum_r;
  logic signed [LW:0]   d_r;
  logic                 neg_r;
  logic signed [W-1:0]  y_r;
  logic                 div_start_r;
  logic [W-1:0]         div_a_r;
  logic [W-1:0]         div_b_r;
  ntc_pkg::out_item_t   res_r;
  ntc_pkg::out_item_t   out_r;
  logic                 out_valid_r;

  logic                 div_done;
  logic [W-1:0]         div_q;
  logic [63:0]          sq;
  logic                 sbit;
  logic [FW-1:0]        frac_nxt;
  logic [LW-1:0]        log_val;
  logic signed [62:0]   ln_prod;
  logic [62:0]          ln_mag;
  logic signed [W-1:0]  t_val;
  logic                 bad_in;

  ntc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sq = 64'(x_r) * 64'(x_r);
  assign sbit = sq[63];
  assign frac_nxt = {frac_r[FW-2:0], sbit};
  assign log_val = {top_r, frac_nxt};
  assign ln_prod = 63'(d_r) * 63'(ntc_pkg::LN2_Q32);
  assign ln_mag = ln_prod[62] ? (~ln_prod + 63'd1) : ln_prod;
  assign t_val = signed'(div_q) - ntc_pkg::KELVIN_CENTI;
  assign bad_in = (mean == '0) || (mean >= ntc_pkg::FULL_SCALE) ||
                  (cfg.series_resistance == '0) || (cfg.nominal_resistance == '0) ||
                  (cfg.beta_factor == '0);
  assign mean_pop = (state_r == B_IDLE) && !mean_empty;
  assign out_empty = !out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      m_r <= '0;
      den_phase_r <= 1'b0;
      x_r <= '0;
      top_r <= '0;
      frac_r <= '0;
      cnt_r <= '0;
      lognum_r <= '0;
      d_r <= '0;
      neg_r <= 1'b0;
      y_r <= '0;
      div_a_r <= '0;
      div_b_r <= '0;
      res_r <= '0;
      out_r <= '0;
    end else begin
      div_start_r <= 1'b0;
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!mean_empty) begin
            m_r <= mean;
            den_phase_r <= 1'b0;
            if (bad_in) begin
              res_r <= '{temperature_centi: ntc_pkg::FAULT_TEMP, fault: 1'b1};
              state_r <= B_DONE;
            end else begin
              state_r <= B_MUL;
            end
          end
        end
        B_MUL: begin
          x_r <= den_phase_r ? 32'((ntc_pkg::FULL_SCALE - m_r) * cfg.nominal_resistance)
                             : 32'(m_r * cfg.series_resistance);
          top_r <= 5'd31;
          cnt_r <= '0;
          state_r <= B_NORM;
        end
        B_NORM: begin
          // Normalize in five halving steps: 16, 8, 4, 2, 1.
          cnt_r <= cnt_r + 1'b1;
          case (cnt_r)
            5'd0: if (x_r[31:16] == '0) begin x_r <= x_r << 16; top_r <= top_r - 5'd16; end
            5'd1: if (x_r[31:24] == '0) begin x_r <= x_r << 8; top_r <= top_r - 5'd8; end
            5'd2: if (x_r[31:28] == '0) begin x_r <= x_r << 4; top_r <= top_r - 5'd4; end
            5'd3: if (x_r[31:30] == '0) begin x_r <= x_r << 2; top_r <= top_r - 5'd2; end
            default: begin
              if (!x_r[31]) begin
                x_r <= x_r << 1;
                top_r <= top_r - 5'd1;
              end
              cnt_r <= '0;
              frac_r <= '0;
              state_r <= B_SQR;
            end
          endcase
        end
        B_SQR: begin
          // Square, keep Q1.31; a square of 2.0 or more gives a one bit.
          x_r <= sbit ? sq[63:32] : sq[62:31];
          frac_r <= frac_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(FW - 1)) begin
            if (!den_phase_r) begin
              lognum_r <= log_val;
              den_phase_r <= 1'b1;
              state_r <= B_MUL;
            end else begin
              d_r <= signed'({1'b0, lognum_r}) - signed'({1'b0, log_val});
              state_r <= B_LN;
            end
          end
        end
        B_LN: begin
          neg_r <= ln_prod[62];
          div_a_r <= {1'b0, ln_mag};
          div_b_r <= W'(cfg.beta_factor);
          div_start_r <= 1'b1;
          state_r <= B_DIVB;
        end
        B_DIVB: begin
          if (div_done) begin
            y_r <= neg_r ? -signed'(div_q) : signed'(div_q);
            div_a_r <= ntc_pkg::CENTI_Q56;
            div_b_r <= W'(W'(cfg.nominal_temp_centi) + ntc_pkg::KELVIN_CENTI);
            div_start_r <= 1'b1;
            state_r <= B_DIVT;
          end
        end
        B_DIVT: begin
          if (div_done) begin
            y_r <= y_r + signed'(div_q);
            state_r <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (y_r[W-1]) begin
            res_r <= '{temperature_centi: ntc_pkg::FAULT_TEMP, fault: 1'b1};
            state_r <= B_DONE;
          end else if (y_r == '0) begin
            res_r <= '{temperature_centi: ntc_pkg::SAT_TEMP, fault: 1'b0};
            state_r <= B_DONE;
          end else begin
            div_a_r <= ntc_pkg::CENTI_Q56;
            div_b_r <= y_r;
            div_start_r <= 1'b1;
            state_r <= B_DIVQ;
          end
        end
        B_DIVQ: begin
          if (div_done) begin
            if (t_val < ntc_pkg::LOW_LIMIT) begin
              res_r <= '{temperature_centi: ntc_pkg::FAULT_TEMP, fault: 1'b1};
            end else if (t_val > ntc_pkg::SAT_HIGH) begin
              res_r <= '{temperature_centi: ntc_pkg::SAT_TEMP, fault: 1'b0};
            end else begin
              res_r <= '{temperature_centi: t_val[15:0], fault: 1'b0};
            end
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid_r || out_pop) begin
            out_r <= res_r;
            out_valid_r <= 1'b1;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/ntc_temperature_averaged.sv]
// Top level of the NTC thermometer: config registers, front, mean queue, back.
// Depends on ntc_pkg, ntc_front, ntc_queue, ntc_back.
//
//  channel | ports                              | transfer
//  --------+------------------------------------+-------------------------------
//  input   | in_push, in_full, in_data          | push && !full
//  result  | out_pop, out_empty, out_data       | pop && !empty
//  config  | cfg_valid, cfg_ready, cfg_index,   | valid && ready (ready always 1)
//          | cfg_wdata                          |
//
// A prime request is taken in the front without leaving idle. A measure request
// holds the front for ring read, sum update, mean by reciprocal multiply and
// hand-off to the queue. Per mean the back runs two logarithms of 1 multiply,
// 5 normalize and 24 squaring steps each, then up to three passes through the
// shared divider (64 quotient bits plus start and hand-back), which sets the
// rate. Reset is synchronous, active low; the ring reads as zero after reset
// through its valid bits, so no clearing pass is needed. A stalled result holds
// in the output register while the queue keeps taking means until it is full.
`timescale 1ns / 1ps

module ntc_temperature_averaged #(
  parameter int AVERAGE_DEPTH = ntc_pkg::AVERAGE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  ntc_pkg::in_item_t              in_data,
  output logic                           in_full,
  output logic                           out_empty,
  output ntc_pkg::out_item_t             out_data,
  input  logic                           out_pop,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = ntc_pkg::SAMPLE_W;

  ntc_pkg::cfg_t cfg_r;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic [SW-1:0] q_in;
  logic [SW-1:0] q_out;

  assign cfg_ready = 1'b1;

  // Hold the conversion constants; writes beyond the last register drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_resistance <= 20'd10000;
      cfg_r.series_resistance <= 20'd10000;
      cfg_r.beta_factor <= 16'd3950;
      cfg_r.nominal_temp_centi <= 15'sd2500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntc_pkg::REG_NOMINAL_RES:  cfg_r.nominal_resistance <= cfg_wdata;
        ntc_pkg::REG_SERIES_RES:   cfg_r.series_resistance <= cfg_wdata;
        ntc_pkg::REG_BETA:         cfg_r.beta_factor <= cfg_wdata[15:0];
        ntc_pkg::REG_NOMINAL_TEMP: cfg_r.nominal_temp_centi <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Front: ring, running sum and mean.
  ntc_front #(.AVERAGE_DEPTH(AVERAGE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .mean_push (q_push),
    .mean      (q_in),
    .mean_full (q_full)
  );

  // Decouple the front from the slow conversion.
  ntc_queue #(.WIDTH(SW), .DEPTH(ntc_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back: beta equation and output register.
  ntc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .mean_empty (q_empty),
    .mean       (q_out),
    .mean_pop   (q_pop),
    .out_empty  (out_empty),
    .out_data   (out_data),
    .out_pop    (out_pop)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed before it was taken");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("mean queue popped while empty");

  a_front_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_full) |=> q_push)
    else $error("front dropped a mean while the queue was full");

endmodule
